@@ design/kvt_pkg.sv @@
// Shared types and constants for the key-value text tokenizer.
`default_nettype none

package kvt_pkg;

  localparam int MaxRes   = 4;
  localparam int GrpCntW  = $clog2(MaxRes + 1);
  localparam int GrpIdxW  = $clog2(MaxRes);
  localparam int ResDepth = 8;
  localparam int ResPtrW  = $clog2(ResDepth);
  localparam int ResCntW  = $clog2(ResDepth + 1);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;

  typedef enum logic [2:0] {
    ModeBetween = 3'd0,
    ModeSlash   = 3'd1,
    ModeComment = 3'd2,
    ModeQuoted  = 3'd3,
    ModeBare    = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EvChar   = 3'd0,
    EvSend   = 3'd1,
    EvBopen  = 3'd2,
    EvBclose = 3'd3,
    EvEot    = 3'd4
  } ev_e;

  typedef struct packed {
    ev_e        kind;
    logic [7:0] ch;
    logic       err;
    logic       last;
  } res_t;

  typedef struct packed {
    mode_e mode;
    logic  esc;
    logic  ended;
  } lex_state_t;

endpackage

`default_nettype wire

@@ design/kvt_lexer.sv @@
// Per-byte tokenizer step: next lexer state and the group of result events.
`default_nettype none

module kvt_lexer (
  input  wire logic [7:0]                         data_byte_i,
  input  wire logic                               final_byte_i,
  input  wire kvt_pkg::lex_state_t                state_i,
  output kvt_pkg::lex_state_t                     state_o,
  output kvt_pkg::res_t [kvt_pkg::MaxRes-1:0]     res_o,
  output logic [kvt_pkg::GrpCntW-1:0]             res_cnt_o
);
  import kvt_pkg::*;

  typedef struct packed {
    mode_e                mode;
    logic                 esc;
    logic [GrpCntW-1:0]   cnt;
    res_t [MaxRes-1:0]    ent;
  } lex_t;

  function automatic lex_t f_emit(lex_t s, ev_e k, logic [7:0] ch, logic err);
    lex_t r;
    r = s;
    if (r.cnt < GrpCntW'(MaxRes)) begin
      r.ent[r.cnt[GrpIdxW-1:0]].kind = k;
      r.ent[r.cnt[GrpIdxW-1:0]].ch   = (k == EvChar) ? ch : 8'h00;
      r.ent[r.cnt[GrpIdxW-1:0]].err  = err;
      r.ent[r.cnt[GrpIdxW-1:0]].last = 1'b0;
      r.cnt = r.cnt + GrpCntW'(1);
    end
    return r;
  endfunction

  function automatic lex_t f_end(lex_t s, logic err);
    lex_t r;
    r = f_emit(s, EvSend, 8'h00, err);
    r.esc  = 1'b0;
    r.mode = ModeBetween;
    return r;
  endfunction

  function automatic lex_t f_str_char(lex_t s, logic [7:0] b);
    lex_t r;
    r = s;
    if (r.esc) begin
      r.esc = 1'b0;
      if (b == ChQuote || b == ChBslash) r = f_emit(r, EvChar, b, 1'b0);
    end else if (b == ChBslash) begin
      r.esc = 1'b1;
    end else begin
      r = f_emit(r, EvChar, b, 1'b0);
    end
    return r;
  endfunction

  function automatic lex_t f_between(lex_t s, logic [7:0] b);
    lex_t r;
    r = s;
    if (b inside {ChSpace, ChTab, ChCr, ChLf}) begin
      r = s;
    end else if (b == ChLbrace) begin
      r = f_emit(r, EvBopen, 8'h00, 1'b0);
    end else if (b == ChRbrace) begin
      r = f_emit(r, EvBclose, 8'h00, 1'b0);
    end else if (b == ChQuote) begin
      r.mode = ModeQuoted;
      r.esc  = 1'b0;
    end else if (b == ChSlash) begin
      r.mode = ModeSlash;
    end else begin
      r.mode = ModeBare;
      r.esc  = 1'b0;
      r = f_str_char(r, b);
    end
    return r;
  endfunction

  function automatic lex_t f_bare(lex_t s, logic [7:0] b);
    lex_t r;
    if (b inside {ChLbrace, ChRbrace, ChSpace, ChTab}) begin
      r = f_between(f_end(s, 1'b0), b);
    end else if (b inside {ChLf, ChCr}) begin
      r = f_end(s, 1'b0);
    end else begin
      r = f_str_char(s, b);
    end
    return r;
  endfunction

  function automatic lex_t f_quoted(lex_t s, logic [7:0] b);
    lex_t r;
    if (!s.esc && b == ChQuote) begin
      r = f_end(s, 1'b0);
    end else if (b inside {ChLf, ChCr}) begin
      r = f_end(s, 1'b1);
    end else begin
      r = f_str_char(s, b);
    end
    return r;
  endfunction

  function automatic lex_t f_finish(lex_t s);
    lex_t r;
    r = s;
    if (r.mode == ModeQuoted || r.mode == ModeBare) begin
      r = f_emit(r, EvSend, 8'h00, 1'b0);
    end else if (r.mode == ModeSlash) begin
      r = f_emit(r, EvChar, ChSlash, 1'b0);
      r = f_emit(r, EvSend, 8'h00, 1'b0);
    end
    r = f_emit(r, EvEot, 8'h00, 1'b0);
    r.mode = ModeBetween;
    r.esc  = 1'b0;
    return r;
  endfunction

  lex_t s0, s1, s2;
  logic ended_d;

  always_comb begin
    s0      = '0;
    s0.mode = state_i.mode;
    s0.esc  = state_i.esc;
    s1      = s0;
    ended_d = state_i.ended;
    if (!state_i.ended) begin
      if (data_byte_i == ChNul) begin
        s1      = f_finish(s0);
        ended_d = 1'b1;
      end else begin
        case (state_i.mode)
          ModeSlash: begin
            if (data_byte_i == ChSlash) begin
              s1.mode = ModeComment;
            end else begin
              s1      = f_emit(s0, EvChar, ChSlash, 1'b0);
              s1.mode = ModeBare;
              s1.esc  = 1'b0;
              s1      = f_bare(s1, data_byte_i);
            end
          end
          ModeComment: begin
            if (data_byte_i == ChLf) s1.mode = ModeBetween;
          end
          ModeQuoted: s1 = f_quoted(s0, data_byte_i);
          ModeBare:   s1 = f_bare(s0, data_byte_i);
          default: begin
            s1.mode = ModeBetween;
            s1      = f_between(s1, data_byte_i);
          end
        endcase
        if (final_byte_i) begin
          s1      = f_finish(s1);
          ended_d = 1'b1;
        end
      end
    end
    s2 = s1;
    if (s1.cnt != '0) begin
      s2.ent[GrpIdxW'(s1.cnt - GrpCntW'(1))].last = 1'b1;
    end
  end

  assign state_o.mode  = s2.mode;
  assign state_o.esc   = s2.esc;
  assign state_o.ended = ended_d;
  assign res_o         = s2.ent;
  assign res_cnt_o     = s2.cnt;

endmodule

`default_nettype wire

@@ design/kvt_result_fifo.sv @@
// Result queue: takes a group of up to four events per beat, sends one per beat.
`default_nettype none

module kvt_result_fifo (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push_i,
  input  wire logic [kvt_pkg::GrpCntW-1:0]         push_cnt_i,
  input  wire kvt_pkg::res_t [kvt_pkg::MaxRes-1:0] push_data_i,
  input  wire logic                                pop_i,
  output logic                                     valid_o,
  output kvt_pkg::res_t                            data_o,
  output logic                                     full_o,
  output logic [kvt_pkg::ResCntW-1:0]              fill_o
);
  import kvt_pkg::*;

  res_t                mem_q [ResDepth];
  logic [ResPtrW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [ResCntW-1:0]  fill_q, fill_d;
  logic [GrpCntW-1:0]  push_n;
  logic                pop;

  assign push_n  = push_i ? push_cnt_i : '0;
  assign pop     = pop_i && (fill_q != '0);
  assign wp_d    = wp_q + ResPtrW'(push_n);
  assign rp_d    = rp_q + ResPtrW'(pop);
  assign fill_d  = fill_q + ResCntW'(push_n) - ResCntW'(pop);
  assign valid_o = (fill_q != '0);
  assign data_o  = mem_q[rp_q];
  assign full_o  = (fill_q > ResCntW'(ResDepth - MaxRes));
  assign fill_o  = fill_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (GrpCntW'(k) < push_n) mem_q[wp_q + ResPtrW'(k)] <= push_data_i[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

endmodule

`default_nettype wire

@@ design/keyvalue_text_tokenizer_core.sv @@
// Top level of the key-value text tokenizer: lexer state, step logic, result queue.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+--------------------------------------------
//   in      | in  | in_valid_i/in_stall_o  | data_byte_i, final_byte_i
//   out     | out | out_valid_o/out_stall_i| event_kind_o, char_value_o, syntax_error_o,
//           |     |                        | run_last_o
//
// One text byte per cycle is taken while in_stall_o is low; its state update is done in
// the same cycle. Each byte gives zero to four events, sent from an 8-entry queue
// one per cycle while out_stall_i is low, so the sustained rate is one byte per cycle
// while bytes average one event or less. in_stall_o rises when the queue has less than
// four free entries. Reset returns the lexer to between tokens and empties the queue.
`default_nettype none

module keyvalue_text_tokenizer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      event_kind_o,
  output logic [7:0]      char_value_o,
  output logic            syntax_error_o,
  output logic            run_last_o
);
  import kvt_pkg::*;

  lex_state_t          st_q, st_d;
  res_t [MaxRes-1:0]   grp;
  logic [GrpCntW-1:0]  grp_cnt;
  logic                in_acc;
  logic                full;
  res_t                head;
  logic [ResCntW-1:0]  fill;

  assign in_stall_o = full;
  assign in_acc     = in_valid_i && !full;

  kvt_lexer u_lexer (
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .state_i      (st_q),
    .state_o      (st_d),
    .res_o        (grp),
    .res_cnt_o    (grp_cnt)
  );

  kvt_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .push_cnt_i  (grp_cnt),
    .push_data_i (grp),
    .pop_i       (!out_stall_i),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .full_o      (full),
    .fill_o      (fill)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode  <= ModeBetween;
      st_q.esc   <= 1'b0;
      st_q.ended <= 1'b0;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  assign event_kind_o   = head.kind;
  assign char_value_o   = head.ch;
  assign syntax_error_o = head.err;
  assign run_last_o     = head.last;

  a_ended_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && st_q.ended |=> fill <= $past(fill))
    else $error("byte after end of text produced events");

  a_nul_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (data_byte_i == ChNul) |=> st_q.ended)
    else $error("NUL byte did not end the text");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= ResCntW'(ResDepth))
    else $error("result queue overfilled");

  a_stall_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> fill <= ResCntW'(ResDepth - MaxRes))
    else $error("input taken without room for a full group");

endmodule

`default_nettype wire
